/* rtl/sfc_pkg.sv */
// Shared types and constants for the sensor frame checker.
// No dependencies; imported by every module of the block.
`default_nettype none

package sfc_pkg;

   // Frame layout
   localparam int unsigned FRAME_LEN = 9;
   localparam int unsigned CNT_W     = 4;
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned RAW_W     = 16;
   localparam int unsigned SCALED_W  = 19;

   localparam logic [CNT_W-1:0] CNT_MAX     = 4'd15;
   localparam logic [CNT_W-1:0] IDX_START   = 4'd0;
   localparam logic [CNT_W-1:0] IDX_TYPE    = 4'd1;
   localparam logic [CNT_W-1:0] IDX_READ_HI = 4'd4;
   localparam logic [CNT_W-1:0] IDX_READ_LO = 4'd5;
   localparam logic [CNT_W-1:0] IDX_FS_HI   = 4'd6;
   localparam logic [CNT_W-1:0] IDX_FS_LO   = 4'd7;

   // Register map
   localparam int unsigned CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TYPE_BYTE  = 2'd1;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'hFF;
   localparam logic [BYTE_W-1:0] TYPE_BYTE_RESET  = 8'h17;

   typedef enum logic [1:0] {
      ST_OK  = 2'd0,
      ST_LEN = 2'd1,
      ST_HDR = 2'd2,
      ST_SUM = 2'd3
   } status_type;

   // One verdict beat
   typedef struct packed {
      status_type          status;
      logic [SCALED_W-1:0] reading_q2;
      logic [SCALED_W-1:0] full_scale_q2;
      logic [CNT_W-1:0]    burst_length;
   } result_type;

   // Raw word times five: (x << 2) + x
   function automatic logic [SCALED_W-1:0] times_five(input logic [RAW_W-1:0] raw);
      logic [SCALED_W-1:0] ext;
      ext = {{(SCALED_W-RAW_W){1'b0}}, raw};
      return (ext << 2) + ext;
   endfunction

endpackage

`default_nettype wire

/* rtl/sfc_frame_acc.sv */
// Per-byte frame state (count, sum, header flag, captured words) and verdict logic.
// Depends on sfc_pkg.
`default_nettype none

module sfc_frame_acc
   import sfc_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_LEN
)
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat,
   input  wire logic [BYTE_W-1:0] rx_byte,
   input  wire logic              burst_end,
   input  wire logic [BYTE_W-1:0] start_byte,
   input  wire logic [BYTE_W-1:0] type_byte,
   output logic                   res_valid,
   output result_type             res_data
);

   logic [CNT_W-1:0]  byte_count_ff, byte_count_in;
   logic [BYTE_W-1:0] running_sum_ff, running_sum_in;
   logic              header_ok_ff, header_ok_in;
   logic [RAW_W-1:0]  reading_raw_ff, reading_raw_in;
   logic [RAW_W-1:0]  full_scale_raw_ff, full_scale_raw_in;
   logic              hdr_miss;

   // Update from the incoming byte
   always_comb begin
      running_sum_in = (byte_count_ff == IDX_START) ? running_sum_ff
                                                    : running_sum_ff + rx_byte;
      hdr_miss = ((byte_count_ff == IDX_START) && (rx_byte != start_byte)) ||
                 ((byte_count_ff == IDX_TYPE)  && (rx_byte != type_byte));
      header_ok_in = header_ok_ff && !hdr_miss;

      reading_raw_in    = reading_raw_ff;
      full_scale_raw_in = full_scale_raw_ff;
      case (byte_count_ff)
         IDX_READ_HI: reading_raw_in    = {rx_byte, reading_raw_ff[BYTE_W-1:0]};
         IDX_READ_LO: reading_raw_in    = {reading_raw_ff[RAW_W-1:BYTE_W], rx_byte};
         IDX_FS_HI:   full_scale_raw_in = {rx_byte, full_scale_raw_ff[BYTE_W-1:0]};
         IDX_FS_LO:   full_scale_raw_in = {full_scale_raw_ff[RAW_W-1:BYTE_W], rx_byte};
         default: ;
      endcase

      byte_count_in = (byte_count_ff < CNT_MAX) ? byte_count_ff + 4'd1 : byte_count_ff;
   end

   // Verdict, priority length > header > checksum
   always_comb begin
      res_valid = beat && burst_end;
      res_data.burst_length  = byte_count_in;
      res_data.reading_q2    = '0;
      res_data.full_scale_q2 = '0;
      if (byte_count_in != CNT_W'(FRAME_BYTES)) begin
         res_data.status = ST_LEN;
      end else if (!header_ok_in) begin
         res_data.status = ST_HDR;
      end else if (running_sum_in != '0) begin
         res_data.status = ST_SUM;
      end else begin
         res_data.status        = ST_OK;
         res_data.reading_q2    = times_five(reading_raw_in);
         res_data.full_scale_q2 = times_five(full_scale_raw_in);
      end
   end

   // Frame state; cleared after each burst end
   always_ff @(posedge clock) begin
      if (reset || (beat && burst_end)) begin
         byte_count_ff     <= '0;
         running_sum_ff    <= '0;
         header_ok_ff      <= 1'b1;
         reading_raw_ff    <= '0;
         full_scale_raw_ff <= '0;
      end else if (beat) begin
         byte_count_ff     <= byte_count_in;
         running_sum_ff    <= running_sum_in;
         header_ok_ff      <= header_ok_in;
         reading_raw_ff    <= reading_raw_in;
         full_scale_raw_ff <= full_scale_raw_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/sfc_out_buf.sv */
// Two-entry result buffer: output register plus skid entry.
// Depends on sfc_pkg.
`default_nettype none

module sfc_out_buf
   import sfc_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   input  wire result_type  push_data,
   output logic             full,
   output logic             out_valid,
   input  wire logic        out_stall,
   output result_type       out_data
);

   logic       main_valid_ff, main_valid_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type main_ff, main_in;
   result_type skid_ff, skid_in;
   logic       pop;

   assign pop       = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

   // Push only arrives while the skid entry is free
   always_comb begin
      main_valid_in = main_valid_ff;
      skid_valid_in = skid_valid_ff;
      main_in       = main_ff;
      skid_in       = skid_ff;
      if (pop) begin
         if (skid_valid_ff) begin
            main_in       = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = push;
            main_in       = push_data;
         end
      end else if (push) begin
         if (!main_valid_ff) begin
            main_valid_in = 1'b1;
            main_in       = push_data;
         end else begin
            skid_valid_in = 1'b1;
            skid_in       = push_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff <= main_in;
      skid_ff <= skid_in;
   end

endmodule

`default_nettype wire

/* rtl/sensor_frame_checker_core.sv */
// Top level of the sensor frame checker: header registers, frame tracker, result buffer.
// Depends on sfc_pkg, sfc_frame_acc and sfc_out_buf.
`default_nettype none

// Checks fixed-length sensor frames (FRAME_BYTES, nine by default) arriving one
// byte per beat. Each byte beat carries a flag marking the last byte of a
// burst; that beat produces one verdict beat (ok, wrong length, bad header,
// bad checksum) with the reading and full scale in quarter-microgram units,
// and the burst length. A byte is taken every clock while req_stall is low: the
// per-byte update is one add and a few compares into the frame registers, so the
// rate is one byte per cycle unless stalled, and the verdict is registered into
// the result buffer. Results sit in a two-entry buffer; req_stall rises only
// while both entries are held. The header registers (start byte, type byte)
// are always ready and should be written only between frames.
module sensor_frame_checker_core
   import sfc_pkg::*;
#(
   parameter int unsigned FRAME_BYTES = FRAME_LEN
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // byte input
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [BYTE_W-1:0]    req_rx_byte,
   input  wire logic                 req_burst_end,
   // verdict output
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [SCALED_W-1:0]       rsp_reading_q2,
   output logic [SCALED_W-1:0]       rsp_full_scale_q2,
   output logic [CNT_W-1:0]          rsp_burst_length,
   // register writes
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [BYTE_W-1:0]    csr_wdata
);

   logic [BYTE_W-1:0] start_byte_ff;
   logic [BYTE_W-1:0] type_byte_ff;
   logic              beat;
   logic              buf_full;
   logic              res_valid;
   result_type        res_data;
   result_type        out_data;

   assign csr_ready = 1'b1;
   assign req_stall = buf_full;
   assign beat      = req_valid && !req_stall;

   // Header registers; other indexes ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         type_byte_ff  <= TYPE_BYTE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_START_BYTE: start_byte_ff <= csr_wdata;
            CSR_TYPE_BYTE:  type_byte_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   sfc_frame_acc #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_frame_acc (
      .clock      (clock),
      .reset      (reset),
      .beat       (beat),
      .rx_byte    (req_rx_byte),
      .burst_end  (req_burst_end),
      .start_byte (start_byte_ff),
      .type_byte  (type_byte_ff),
      .res_valid  (res_valid),
      .res_data   (res_data)
   );

   sfc_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res_data),
      .full      (buf_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_data  (out_data)
   );

   assign rsp_status        = out_data.status;
   assign rsp_reading_q2    = out_data.reading_q2;
   assign rsp_full_scale_q2 = out_data.full_scale_q2;
   assign rsp_burst_length  = out_data.burst_length;

endmodule

`default_nettype wire
